[hw/rtl/fpt_pkg.sv]
`timescale 1ns / 1ps

package fpt_pkg;

   // coordinate and quaternion component width
   localparam int unsigned DW = 32;
   // pair product of components after the drop of 30 fraction bits
   localparam int unsigned QW = 34;
   // matrix entry and norm width
   localparam int unsigned EW = 36;
   // entry times a 16-bit half of a coordinate
   localparam int unsigned PW = 53;
   // row accumulator width
   localparam int unsigned SW = 56;
   // half-word split of Q16.16 values
   localparam int unsigned HW = 16;
   // remaining shift after the low half is folded in
   localparam int unsigned RS = 14;

   localparam int unsigned IW = 3;

   // configuration register indexes
   localparam logic [IW-1:0] REG_ROT_W    = 3'd0;
   localparam logic [IW-1:0] REG_ROT_X    = 3'd1;
   localparam logic [IW-1:0] REG_ROT_Y    = 3'd2;
   localparam logic [IW-1:0] REG_ROT_Z    = 3'd3;
   localparam logic [IW-1:0] REG_OFFSET_X = 3'd4;
   localparam logic [IW-1:0] REG_OFFSET_Y = 3'd5;
   localparam logic [IW-1:0] REG_OFFSET_Z = 3'd6;

   // 1.0 in Q2.30
   localparam logic [DW-1:0] ROT_W_RESET = 32'h4000_0000;

   // cycles for the coefficient pipeline to settle after a write
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   localparam logic [DW-1:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [DW-1:0] SAT_MIN = 32'h8000_0000;

   // frame coefficients handed to the point datapath
   typedef struct packed {
      logic [2:0][2:0][EW-1:0] m;    // rotation matrix, Q.30
      logic [2:0][PW-1:0]      nth;  // norm times offset high half
      logic [2:0][PW-1:0]      ntl;  // norm times offset low half
   } coef_type;

endpackage

[hw/rtl/fpt_req_if.sv]
`timescale 1ns / 1ps

interface fpt_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [fpt_pkg::DW-1:0] point_x;
   logic signed [fpt_pkg::DW-1:0] point_y;
   logic signed [fpt_pkg::DW-1:0] point_z;

   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink   (input valid, input point_x, input point_y, input point_z,
                   output ready);
endinterface

[hw/rtl/fpt_rsp_if.sv]
`timescale 1ns / 1ps

interface fpt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic signed [fpt_pkg::DW-1:0] out_x;
   logic signed [fpt_pkg::DW-1:0] out_y;
   logic signed [fpt_pkg::DW-1:0] out_z;
   logic                        saturated;

   modport source (output valid, output out_x, output out_y, output out_z,
                   output saturated, input ready);
   modport sink   (input valid, input out_x, input out_y, input out_z,
                   input saturated, output ready);
endinterface

[hw/rtl/fpt_coef.sv]
`timescale 1ns / 1ps

module fpt_coef (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [fpt_pkg::IW-1:0]        csr_index,
   input  logic [fpt_pkg::DW-1:0]        csr_wdata,
   output fpt_pkg::coef_type             coef,
   output logic                          coef_ready
);

   logic [fpt_pkg::DW-1:0] rot_w_ff, rot_x_ff, rot_y_ff, rot_z_ff;
   logic [2:0][fpt_pkg::DW-1:0] offset_ff;
   logic [1:0] settle_ff, settle_in;

   // pair products, Q.30
   logic [9:0][fpt_pkg::QW-1:0] prod_ff, prod_in;
   // matrix entries, norm and offset copy
   logic [2:0][2:0][fpt_pkg::EW-1:0] m_ff, m_in;
   logic [fpt_pkg::EW-1:0] norm_ff, norm_in;
   logic [2:0][fpt_pkg::DW-1:0] toff_ff;
   // final coefficient set
   fpt_pkg::coef_type coef_ff, coef_in;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         rot_w_ff  <= fpt_pkg::ROT_W_RESET;
         rot_x_ff  <= '0;
         rot_y_ff  <= '0;
         rot_z_ff  <= '0;
         offset_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            fpt_pkg::REG_ROT_W:    rot_w_ff     <= csr_wdata;
            fpt_pkg::REG_ROT_X:    rot_x_ff     <= csr_wdata;
            fpt_pkg::REG_ROT_Y:    rot_y_ff     <= csr_wdata;
            fpt_pkg::REG_ROT_Z:    rot_z_ff     <= csr_wdata;
            fpt_pkg::REG_OFFSET_X: offset_ff[0] <= csr_wdata;
            fpt_pkg::REG_OFFSET_Y: offset_ff[1] <= csr_wdata;
            fpt_pkg::REG_OFFSET_Z: offset_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // hold off points until the coefficients have caught up with a write
   always_comb begin
      if (csr_wr_en) begin
         settle_in = fpt_pkg::SETTLE_CYCLES;
      end else if (settle_ff != 2'd0) begin
         settle_in = settle_ff - 2'd1;
      end else begin
         settle_in = settle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= fpt_pkg::SETTLE_CYCLES;
      end else begin
         settle_ff <= settle_in;
      end
   end

   assign coef_ready = (settle_ff == 2'd0);

   // stage A: ten pair products, floor to Q.30
   always_comb begin
      logic signed [2*fpt_pkg::DW-1:0] w, x, y, z;
      logic signed [2*fpt_pkg::DW-1:0] pr [10];
      w = (2*fpt_pkg::DW)'($signed(rot_w_ff));
      x = (2*fpt_pkg::DW)'($signed(rot_x_ff));
      y = (2*fpt_pkg::DW)'($signed(rot_y_ff));
      z = (2*fpt_pkg::DW)'($signed(rot_z_ff));
      pr[0] = w * w;
      pr[1] = x * x;
      pr[2] = y * y;
      pr[3] = z * z;
      pr[4] = w * x;
      pr[5] = w * y;
      pr[6] = w * z;
      pr[7] = x * y;
      pr[8] = x * z;
      pr[9] = y * z;
      for (int i = 0; i < 10; i++) begin
         prod_in[i] = pr[i][2*fpt_pkg::DW-1:30];
      end
   end

   // stage B: matrix entries and norm
   always_comb begin
      logic signed [fpt_pkg::EW-1:0] ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
      ww = fpt_pkg::EW'($signed(prod_ff[0]));
      xx = fpt_pkg::EW'($signed(prod_ff[1]));
      yy = fpt_pkg::EW'($signed(prod_ff[2]));
      zz = fpt_pkg::EW'($signed(prod_ff[3]));
      wx = fpt_pkg::EW'($signed(prod_ff[4]));
      wy = fpt_pkg::EW'($signed(prod_ff[5]));
      wz = fpt_pkg::EW'($signed(prod_ff[6]));
      xy = fpt_pkg::EW'($signed(prod_ff[7]));
      xz = fpt_pkg::EW'($signed(prod_ff[8]));
      yz = fpt_pkg::EW'($signed(prod_ff[9]));
      m_in[0][0] = ww + xx - yy - zz;
      m_in[0][1] = xy + xy + wz + wz;
      m_in[0][2] = xz + xz - wy - wy;
      m_in[1][0] = xy + xy - wz - wz;
      m_in[1][1] = ww - xx + yy - zz;
      m_in[1][2] = yz + yz + wx + wx;
      m_in[2][0] = xz + xz + wy + wy;
      m_in[2][1] = yz + yz - wx - wx;
      m_in[2][2] = ww - xx - yy + zz;
      norm_in    = ww + xx + yy + zz;
   end

   // stage C: norm times offset, split into 16-bit halves
   always_comb begin
      logic signed [fpt_pkg::PW-1:0] n, th, tl;
      n = fpt_pkg::PW'($signed(norm_ff));
      coef_in.m = m_ff;
      for (int r = 0; r < 3; r++) begin
         th = fpt_pkg::PW'($signed(toff_ff[r][fpt_pkg::DW-1:fpt_pkg::HW]));
         tl = fpt_pkg::PW'($signed({1'b0, toff_ff[r][fpt_pkg::HW-1:0]}));
         coef_in.nth[r] = n * th;
         coef_in.ntl[r] = n * tl;
      end
   end

   // advance the coefficient stages every cycle
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      m_ff    <= m_in;
      norm_ff <= norm_in;
      toff_ff <= offset_ff;
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;

endmodule

[hw/rtl/fpt_datapath.sv]
`timescale 1ns / 1ps

module fpt_datapath (
   input  logic              clock,
   input  logic              reset,
   input  fpt_pkg::coef_type coef,
   input  logic              coef_ready,
   fpt_req_if.sink           req_bus,
   fpt_rsp_if.source         rsp_bus
);

   localparam int unsigned TOP_LO = fpt_pkg::RS + fpt_pkg::DW - 1;

   logic v1_ff, v2_ff, v3_ff;
   logic en1, en2, en3;

   logic [2:0][2:0][fpt_pkg::PW-1:0] hi_prod_ff, hi_prod_in;
   logic [2:0][2:0][fpt_pkg::PW-1:0] lo_prod_ff, lo_prod_in;
   logic [2:0][fpt_pkg::SW-1:0] hi_sum_ff, hi_sum_in;
   logic [2:0][fpt_pkg::SW-1:0] lo_sum_ff, lo_sum_in;
   logic [2:0][fpt_pkg::DW-1:0] out_ff, out_in;
   logic sat_ff, sat_in;

   // stage enables: a stage moves when empty or when its successor moves
   assign en3 = !v3_ff || rsp_bus.ready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_bus.ready = en1 && coef_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_bus.valid && req_bus.ready;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   // stage 1: entry times each half of the point coordinates
   always_comb begin
      logic [2:0][fpt_pkg::DW-1:0] pt;
      logic signed [fpt_pkg::PW-1:0] e, ph, pl;
      pt[0] = req_bus.point_x;
      pt[1] = req_bus.point_y;
      pt[2] = req_bus.point_z;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            e  = fpt_pkg::PW'($signed(coef.m[r][c]));
            ph = fpt_pkg::PW'($signed(pt[c][fpt_pkg::DW-1:fpt_pkg::HW]));
            pl = fpt_pkg::PW'($signed({1'b0, pt[c][fpt_pkg::HW-1:0]}));
            hi_prod_in[r][c] = e * ph;
            lo_prod_in[r][c] = e * pl;
         end
      end
   end

   // stage 2: row sums less the scaled offset
   always_comb begin
      logic signed [fpt_pkg::SW-1:0] hs, ls;
      for (int r = 0; r < 3; r++) begin
         hs = -fpt_pkg::SW'($signed(coef.nth[r]));
         ls = -fpt_pkg::SW'($signed(coef.ntl[r]));
         for (int c = 0; c < 3; c++) begin
            hs = hs + fpt_pkg::SW'($signed(hi_prod_ff[r][c]));
            ls = ls + fpt_pkg::SW'($signed(lo_prod_ff[r][c]));
         end
         hi_sum_in[r] = hs;
         lo_sum_in[r] = ls;
      end
   end

   // stage 3: fold halves, floor to Q16.16 and clip
   always_comb begin
      logic signed [fpt_pkg::SW-1:0] tot;
      logic clip_hi, clip_lo;
      sat_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         tot = $signed(hi_sum_ff[r]) + ($signed(lo_sum_ff[r]) >>> fpt_pkg::HW);
         clip_hi = !tot[fpt_pkg::SW-1] && (tot[fpt_pkg::SW-2:TOP_LO] != '0);
         clip_lo = tot[fpt_pkg::SW-1] && (tot[fpt_pkg::SW-2:TOP_LO] != '1);
         if (clip_hi) begin
            out_in[r] = fpt_pkg::SAT_MAX;
         end else if (clip_lo) begin
            out_in[r] = fpt_pkg::SAT_MIN;
         end else begin
            out_in[r] = tot[TOP_LO:fpt_pkg::RS];
         end
         sat_in = sat_in | clip_hi | clip_lo;
      end
   end

   // payload registers, held while their stage is stalled
   always_ff @(posedge clock) begin
      if (en1) begin
         hi_prod_ff <= hi_prod_in;
         lo_prod_ff <= lo_prod_in;
      end
      if (en2) begin
         hi_sum_ff <= hi_sum_in;
         lo_sum_ff <= lo_sum_in;
      end
      if (en3) begin
         out_ff <= out_in;
         sat_ff <= sat_in;
      end
   end

   assign rsp_bus.valid     = v3_ff;
   assign rsp_bus.out_x     = out_ff[0];
   assign rsp_bus.out_y     = out_ff[1];
   assign rsp_bus.out_z     = out_ff[2];
   assign rsp_bus.saturated = sat_ff;

endmodule

[hw/rtl/frame_point_transform.sv]
`timescale 1ns / 1ps

// Converts a stream of 3D points (Q16.16) into a target frame given by a
// quaternion (Q2.30, not normalised) and an origin offset (Q16.16).
// Channels: req_bus carries one point per beat, rsp_bus one converted point
// per beat plus a flag that is set when any coordinate was clipped.
// Configuration: csr_wr_en with csr_index and csr_wdata writes one register
// (0..3 quaternion w,x,y,z; 4..6 offset x,y,z); other indexes are dropped.
// A point accepted on req_bus is registered in stage 1, stage 2 and stage 3
// before it is offered on rsp_bus. Throughput: one point per cycle while
// rsp_bus.ready and coefficient readiness allow it, set by the three-stage
// multiply, sum and clip pipeline.
// After reset and after any register write, req_bus.ready stays low while
// the coefficient pipeline (pair products, matrix, norm times offset)
// recomputes. Reset sets the quaternion to identity and the offset to zero,
// and empties the pipeline.
// When the receiver stalls, each stage holds its beat and the pipeline
// fills; req_bus.ready falls only once every stage holds a beat.
module frame_point_transform (
   input  logic                   clock,
   input  logic                   reset,
   fpt_req_if.sink                req_bus,
   fpt_rsp_if.source              rsp_bus,
   input  logic                   csr_wr_en,
   input  logic [fpt_pkg::IW-1:0] csr_index,
   input  logic [fpt_pkg::DW-1:0] csr_wdata
);

   fpt_pkg::coef_type coef;
   logic              coef_ready;

   fpt_coef u_coef (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .coef       (coef),
      .coef_ready (coef_ready)
   );

   fpt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .coef       (coef),
      .coef_ready (coef_ready),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus)
   );

endmodule
